FILE: hw/rtl/jh2d_pkg.sv
// Package for the joint intensity histogram block: payload structs, command
// and internal operation codes, the back-end state type and default sizes.
// Depends on nothing; the top level, front end and back end import it.
package jh2d_pkg;

    localparam int MAX_LEVELS_DEF = 256;
    localparam int COUNT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int LEVEL_W   = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 9;
    localparam int CNT_OUT_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);
    // Largest number of levels that an 8-bit coordinate can address.
    localparam logic [CFG_W-1:0] CFG_CAP   = CFG_W'(2 ** LEVEL_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCUM   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_CLR_ERR = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    localparam int OP_W = 3;

    // Operations after classification by the front end.
    typedef enum logic [OP_W-1:0] {
        OP_INC     = 3'd0,
        OP_FETCH   = 3'd1,
        OP_SET_ERR = 3'd2,
        OP_CLR_ERR = 3'd3,
        OP_MISS    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_RMW   = 3'b100
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LEVEL_W-1:0] first_level;
        logic [LEVEL_W-1:0] second_level;
    } jh2d_in_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] bin_count;
        logic                 error_seen;
    } jh2d_out_t;

endpackage

FILE: hw/rtl/joint_histogram_2d.sv
// Top level of the joint intensity histogram block: front end, operation queue
// and back end with the bin store. Depends on jh2d_pkg, jh2d_front, jh2d_fifo
// and jh2d_back (which holds jh2d_ram).
//
//   Channel   Ports                         Carries
//   input     s_valid, s_ready, s_data      command and two 8-bit levels
//   result    m_valid, m_ready, m_data      bin count and sticky error flag
//   config    cfg_wr_en, cfg_wr_data        bins_per_axis, written at once
//
// Clear-error beats, out-of-range beats and out-of-range reads are done in the
// idle state alone; accumulate and in-range read beats also pass the update state,
// because the bin store has one registered read followed by one write-back per beat.
// After reset the back end clears the store one bin per cycle, all 2**(2*ceil(log2
// MAX_LEVELS)) bins (65536 at the default size); s_ready stays low until then.
// A two-entry queue lets the input side keep accepting while the back end or a
// pending result on the m_ side stalls.
module joint_histogram_2d
    import jh2d_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  jh2d_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output jh2d_out_t        m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    // Bin address: column index above row index, each wide enough for MAX_LEVELS.
    localparam int ADDR_W = 2 * $clog2(MAX_LEVELS);
    localparam int QW     = OP_W + ADDR_W;

    logic          clearing;
    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_push_ready;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_data;

    // The front end range checks against min(bins_per_axis, MAX_LEVELS, 256) and
    // drops the unused command, so every queued beat does something.
    jh2d_front #(
        .MAX_LEVELS(MAX_LEVELS),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .clearing   (clearing),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .q_ready    (q_push_ready)
    );

    jh2d_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .push_ready(q_push_ready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    // The back end applies operations strictly in order, so each read sees
    // the error flag as left by every earlier beat.
    jh2d_back #(
        .COUNT_BITS(COUNT_BITS),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .clearing(clearing),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: hw/rtl/jh2d_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module jh2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/jh2d_fifo.sv
// Small register queue that decouples the front end from the back end.
// Depends on nothing.
module jh2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/jh2d_front.sv
// Front end: holds the bins_per_axis register, accepts input beats, range
// checks the coordinates and turns each beat into an operation with a bin
// address for the queue. Depends on jh2d_pkg.
module jh2d_front
    import jh2d_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int ADDR_W     = 2 * $clog2(MAX_LEVELS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  jh2d_in_t               s_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   clearing,
    output logic                   q_push,
    output logic [OP_W+ADDR_W-1:0] q_data,
    input  logic                   q_ready
);

    localparam int LB = ADDR_W / 2;
    localparam logic [CFG_W-1:0] LEVEL_CAP =
        (MAX_LEVELS > 2 ** LEVEL_W) ? CFG_CAP : CFG_W'(MAX_LEVELS);

    logic [CFG_W-1:0]  cfg_reg;
    logic [CFG_W-1:0]  eff_bins;
    logic              in_range;
    logic              keep;
    op_t               op;
    logic              fr_valid_reg, fr_valid_next;
    op_t               fr_op_reg;
    logic [ADDR_W-1:0] fr_addr_reg;
    logic              accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    assign eff_bins = (cfg_reg > LEVEL_CAP) ? LEVEL_CAP : cfg_reg;
    assign in_range = ({1'b0, s_data.first_level} < eff_bins)
                   && ({1'b0, s_data.second_level} < eff_bins);

    always_comb begin
        keep = 1'b1;
        op   = OP_CLR_ERR;
        case (cmd_t'(s_data.command))
            CMD_ACCUM:   op = in_range ? OP_INC : OP_SET_ERR;
            CMD_READ:    op = in_range ? OP_FETCH : OP_MISS;
            CMD_CLR_ERR: op = OP_CLR_ERR;
            default:     keep = 1'b0;
        endcase
    end

    assign q_push  = fr_valid_reg && q_ready;
    assign s_ready = !clearing && (!fr_valid_reg || q_ready);
    assign accept  = s_valid && s_ready;
    assign q_data  = {fr_op_reg, fr_addr_reg};

    always_comb begin
        fr_valid_next = fr_valid_reg;
        if (q_push) begin
            fr_valid_next = 1'b0;
        end
        if (accept) begin
            fr_valid_next = keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    // The bin address packs the column above the row.
    always_ff @(posedge aclk) begin
        if (accept) begin
            fr_op_reg   <= op;
            fr_addr_reg <= {LB'(s_data.second_level), LB'(s_data.first_level)};
        end
    end

endmodule

FILE: hw/rtl/jh2d_back.sv
// Back end: clears the bin store after reset, performs the read-modify-write
// of each queued accumulate or in-range read, keeps the sticky error flag and
// the output register. Depends on jh2d_pkg and jh2d_ram.
module jh2d_back
    import jh2d_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int ADDR_W     = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  logic [OP_W+ADDR_W-1:0] q_data,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   m_valid,
    input  logic                   m_ready,
    output jh2d_out_t              m_data
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    jh2d_out_t         out_reg, out_next;
    op_t               cur_op_reg;
    logic [ADDR_W-1:0] cur_addr_reg;
    op_t               q_op;
    logic [ADDR_W-1:0] q_addr;
    logic              out_free;
    logic              out_load;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_rdata;

    assign q_op     = op_t'(q_data[OP_W+ADDR_W-1 -: OP_W]);
    assign q_addr   = q_data[ADDR_W-1:0];
    assign out_free = !out_valid_reg || m_ready;
    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && out_free;
    assign ram_re   = q_pop && (q_op == OP_INC || q_op == OP_FETCH);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        err_next      = err_reg;
        out_load      = 1'b0;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = cur_addr_reg;
        ram_wdata     = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    case (q_op)
                        OP_INC, OP_FETCH: state_next = ST_RMW;
                        OP_SET_ERR:       err_next = 1'b1;
                        OP_CLR_ERR:       err_next = 1'b0;
                        OP_MISS: begin
                            out_load = 1'b1;
                            out_next = '{bin_count: '0, error_seen: err_reg};
                        end
                        default: ;
                    endcase
                end
            end
            ST_RMW: begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
                if (cur_op_reg == OP_FETCH) begin
                    out_load = 1'b1;
                    out_next = '{bin_count: CNT_OUT_W'(ram_rdata), error_seen: err_reg};
                end else begin
                    ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata
                                                       : ram_rdata + COUNT_BITS'(1);
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (q_pop) begin
            cur_op_reg   <= q_op;
            cur_addr_reg <= q_addr;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    jh2d_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(2 ** ADDR_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(q_addr),
        .rd_data(ram_rdata)
    );

`ifndef SYNTHESIS
    // The store is only written by the clearing sweep or the write half of an update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("bin store written while back end idle");

    // A new result never overwrites one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");

    // After the write of an update the back end always returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW) |=> (state_reg == ST_IDLE))
        else $error("update did not return to idle");

    // Memory operations popped from the queue always enter the update cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> (state_reg == ST_RMW))
        else $error("bin read without update");
`endif

endmodule
